// ===== hdl/cft_pkg.sv =====
package cft_pkg;

  localparam int NUM_PROCS   = 8;
  localparam int FUEL        = 8;
  localparam int TABLE_DEPTH = 64;

  localparam int IDX_W   = 6;
  localparam int OWNER_W = 8;
  localparam int FUEL_W  = 4;
  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SUM_W   = IDX_W + 1;
  localparam int REV_W   = ($clog2(FUEL + 1) > FUEL_W) ? $clog2(FUEL + 1) : FUEL_W;

  localparam logic [FUEL_W-1:0] FUEL_MAX = '1;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [OWNER_W-1:0] pid;
    logic [FUEL_W-1:0]  free;
    logic [FUEL_W-1:0]  size;
  } cft_entry_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    cft_entry_t         data;
  } cft_wr_t;

  typedef enum logic [2:0] {
    REQ_GET      = 3'd0,
    REQ_TRANSFER = 3'd1,
    REQ_DERIVE   = 3'd2,
    REQ_REVOKE   = 3'd3,
    REQ_DELETE   = 3'd4
  } cft_req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ACCESS = 2'd1,
    STAT_ARG    = 2'd2
  } cft_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DERIVE_WR,
    S_REV_TEST,
    S_REV_CHILD,
    S_RESULT
  } cft_state_e;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   child;
    logic [OWNER_W-1:0] owner;
    logic [OWNER_W-1:0] pid;
    logic [FUEL_W-1:0]  free;
    logic [FUEL_W-1:0]  size;
    logic [FUEL_W-1:0]  unrevoked;
  } cft_res_t;

  function automatic cft_entry_t cft_reset_entry(input logic [ADDR_W-1:0] addr);
    cft_entry_t e;
    e = '0;
    for (int k = 0; k < NUM_PROCS; k++) begin
      if ((k * FUEL < TABLE_DEPTH) && (int'(addr) == k * FUEL)) begin
        e.owner = OWNER_W'(1);
        e.pid   = OWNER_W'(k + 1);
        e.free  = FUEL_W'(FUEL);
        e.size  = FUEL_W'(FUEL);
      end
    end
    return e;
  endfunction

endpackage

// ===== hdl/cft_store.sv =====
module cft_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [cft_pkg::ADDR_W-1:0]  rd_addr_i,
  input  cft_pkg::cft_wr_t            wr_i,
  output cft_pkg::cft_entry_t         rd_data_o
);
  import cft_pkg::*;

  cft_entry_t              mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  vld_q;
  cft_entry_t              rd_q;
  logic                    rd_vld_q;
  logic [ADDR_W-1:0]       rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q      <= mem_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // Entries never written since reset read back their reset contents from cft_reset_entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : cft_reset_entry(rd_addr_q);

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.en && rd_en_i) |-> (wr_i.addr != rd_addr_i))
    else $error("read and write hit the same entry in one cycle");
`endif

endmodule

// ===== hdl/capability_fuel_table_top.sv =====
// Get, transfer, delete and rejected requests present their result from S_LOOKUP,
// derive from S_DERIVE_WR, and revoke after alternating S_REV_TEST and S_REV_CHILD
// per child walked, ending in S_REV_CHILD if the walk stops at a child without fuel.
// A request is taken only in S_IDLE, once the table's read and write-back for the last
// are done; a new request is taken while one result waits in the output register.
// Reset is asynchronous and active low; it restores the table.
module capability_fuel_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // requester, cap_index, next_owner, fuel_amount, revoke_limit
  input  logic [31:0] s_axis_tdata_i,
  // req_type
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // child_index, out_owner, out_pid, out_free, out_size, unrevoked
  output logic [39:0] m_axis_tdata_o,
  // status
  output logic [1:0]  m_axis_tuser_o
);
  import cft_pkg::*;

  cft_state_e          state_q, state_d;
  logic [2:0]          req_type_q;
  logic [OWNER_W-1:0]  requester_q;
  logic [IDX_W-1:0]    idx_q;
  logic [OWNER_W-1:0]  next_owner_q;
  logic [FUEL_W-1:0]   fuel_q;
  logic [FUEL_W-1:0]   limit_q;
  cft_entry_t          ent_q, ent_d;
  logic [SUM_W-1:0]    child_q, child_d;
  logic [REV_W-1:0]    rev_left_q, rev_left_d;
  cft_res_t            res_q, res_d;
  logic                res_vld;
  logic                go_derive, go_revoke, loop_done;
  logic                m_valid_q;
  cft_res_t            m_res_q;

  logic                accept, slot_free;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  cft_wr_t             wr;
  cft_entry_t          rd_data;

  logic                granted;
  logic [FUEL_W-1:0]   rest;
  logic [SUM_W-1:0]    derive_j, rev_j;
  logic [FUEL_W:0]     fuel_sum;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !m_valid_q || m_axis_tready_i;

  cft_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  assign granted  = (int'(idx_q) < TABLE_DEPTH) && (rd_data.owner == requester_q);
  assign rest     = rd_data.free - fuel_q;
  assign derive_j = SUM_W'(idx_q) + SUM_W'(rest);
  assign rev_j    = SUM_W'(idx_q) + SUM_W'(ent_q.free);
  assign fuel_sum = {1'b0, ent_q.free} + {1'b0, rd_data.free};

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = ADDR_W'(s_axis_tdata_i[13:8]);
    wr         = '0;
    res_d      = '0;
    res_vld    = 1'b0;
    ent_d      = ent_q;
    child_d    = child_q;
    rev_left_d = rev_left_q;
    go_derive  = 1'b0;
    go_revoke  = 1'b0;
    loop_done  = 1'b0;
    case (state_q)
      S_IDLE: begin
        rd_en = accept;
      end
      S_LOOKUP: begin
        if (req_type_q > REQ_DELETE) begin
          res_d.status = STAT_ARG;
          res_vld      = 1'b1;
        end else if (!granted) begin
          res_d.status = STAT_ACCESS;
          res_vld      = 1'b1;
        end else begin
          wr.addr = ADDR_W'(idx_q);
          wr.data = rd_data;
          case (req_type_q)
            REQ_GET: begin
              res_d.owner = rd_data.owner;
              res_d.pid   = rd_data.pid;
              res_d.free  = rd_data.free;
              res_d.size  = rd_data.size;
              res_vld     = 1'b1;
            end
            REQ_TRANSFER: begin
              wr.en         = 1'b1;
              wr.data.owner = next_owner_q;
              res_vld       = 1'b1;
            end
            REQ_DERIVE: begin
              if (fuel_q == '0 || rd_data.free < fuel_q ||
                  int'(derive_j) >= TABLE_DEPTH) begin
                res_d.status = STAT_ARG;
                res_vld      = 1'b1;
              end else begin
                wr.en        = 1'b1;
                wr.data.free = rest;
                ent_d        = rd_data;
                child_d      = derive_j;
                go_derive    = 1'b1;
              end
            end
            REQ_REVOKE: begin
              ent_d      = rd_data;
              rev_left_d = (limit_q != '0) ? REV_W'(limit_q) : REV_W'(FUEL);
              go_revoke  = 1'b1;
            end
            default: begin
              wr.en         = 1'b1;
              wr.data.owner = '0;
              res_vld       = 1'b1;
            end
          endcase
        end
      end
      S_DERIVE_WR: begin
        wr.en         = 1'b1;
        wr.addr       = ADDR_W'(child_q);
        wr.data.owner = next_owner_q;
        wr.data.pid   = ent_q.pid;
        wr.data.free  = fuel_q;
        wr.data.size  = fuel_q;
        res_d.child   = IDX_W'(child_q);
        res_vld       = 1'b1;
      end
      S_REV_TEST: begin
        if (rev_left_q == '0 || ent_q.free >= ent_q.size || ent_q.free == '0 ||
            int'(rev_j) >= TABLE_DEPTH) begin
          loop_done = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(rev_j);
        end
      end
      S_REV_CHILD: begin
        if (rd_data.free == '0) begin
          loop_done = 1'b1;
        end else begin
          wr.en         = 1'b1;
          wr.addr       = ADDR_W'(rev_j);
          wr.data       = rd_data;
          wr.data.owner = '0;
          ent_d.free    = fuel_sum[FUEL_W] ? FUEL_MAX : fuel_sum[FUEL_W-1:0];
          rev_left_d    = rev_left_q - REV_W'(1);
        end
      end
      S_RESULT: begin
        res_d   = res_q;
        res_vld = 1'b1;
      end
      default: begin
      end
    endcase
    if (loop_done) begin
      wr.en   = 1'b1;
      wr.addr = ADDR_W'(idx_q);
      wr.data = ent_q;
      res_d.unrevoked = (ent_q.size > ent_q.free) ? (ent_q.size - ent_q.free) : '0;
      res_vld = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (go_derive) begin
          state_d = S_DERIVE_WR;
        end else if (go_revoke) begin
          state_d = S_REV_TEST;
        end else begin
          state_d = slot_free ? S_IDLE : S_RESULT;
        end
      end
      S_REV_TEST: begin
        if (loop_done) begin
          state_d = slot_free ? S_IDLE : S_RESULT;
        end else begin
          state_d = S_REV_CHILD;
        end
      end
      S_REV_CHILD: begin
        if (loop_done) begin
          state_d = slot_free ? S_IDLE : S_RESULT;
        end else begin
          state_d = S_REV_TEST;
        end
      end
      S_DERIVE_WR, S_RESULT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_RESULT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_vld && slot_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q   <= s_axis_tuser_i;
      requester_q  <= s_axis_tdata_i[7:0];
      idx_q        <= s_axis_tdata_i[13:8];
      next_owner_q <= s_axis_tdata_i[21:14];
      fuel_q       <= s_axis_tdata_i[25:22];
      limit_q      <= s_axis_tdata_i[29:26];
    end
    ent_q      <= ent_d;
    child_q    <= child_d;
    rev_left_q <= rev_left_d;
    if (res_vld) begin
      res_q <= res_d;
    end
    if (res_vld && slot_free) begin
      m_res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_res_q.status;
  assign m_axis_tdata_o  = {6'b0, m_res_q.unrevoked, m_res_q.size, m_res_q.free,
                            m_res_q.pid, m_res_q.owner, m_res_q.child};

`ifndef SYNTHESIS
  a_derive_child_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DERIVE_WR) |-> (int'(child_q) < TABLE_DEPTH))
    else $error("derived child lies outside the table");
  a_revoke_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REV_CHILD) |-> (rev_left_q != '0))
    else $error("revoke walked a child past its step budget");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESULT) |-> !wr.en)
    else $error("table written while no request is in progress");
`endif

endmodule

// ===== dv/tb_capability_fuel_table_top.sv =====
module tb_capability_fuel_table_top;
  import cft_pkg::*;

  localparam logic [2:0] REQ_RSVD_5 = 3'd5;
  localparam logic [2:0] REQ_RSVD_6 = 3'd6;
  localparam logic [2:0] REQ_RSVD_7 = 3'd7;
  localparam int RANDOM_REQUESTS = 1600;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [2:0]         kind;
    logic [OWNER_W-1:0] who;
    logic [IDX_W-1:0]   idx;
    logic [OWNER_W-1:0] owner_to;
    logic [FUEL_W-1:0]  fuel;
    logic [FUEL_W-1:0]  limit;
    bit                 typed;
    cft_res_t           want;
  } cap_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  logic [OWNER_W-1:0] cap_owner [TABLE_DEPTH];
  logic [OWNER_W-1:0] cap_pid   [TABLE_DEPTH];
  logic [FUEL_W-1:0]  cap_free  [TABLE_DEPTH];
  logic [FUEL_W-1:0]  cap_size  [TABLE_DEPTH];

  cap_cmd_t directed_cmds [$];
  cft_res_t pending_results [$];
  int       kind_count [8];
  int       results_seen = 0;
  int       mismatches = 0;
  bit       calm = 1'b0;
  int       hold_asked = 0;
  int       hold_done = 0;
  int       hold_cycles = 0;

  capability_fuel_table_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic cft_res_t fixed(input cft_status_e status, input logic [7:0] owner,
                                     input logic [7:0] pid, input logic [3:0] free,
                                     input logic [3:0] size);
    cft_res_t r;
    r        = '0;
    r.status = status;
    r.owner  = owner;
    r.pid    = pid;
    r.free   = free;
    r.size   = size;
    return r;
  endfunction

  // Applies one request to the shadow table and returns the result it produces.
  function automatic cft_res_t cap_table_step(input cap_cmd_t c);
    cft_res_t r;
    int       i;
    int       rest;
    int       child;
    int       steps;
    int       sum;
    r = '0;
    i = int'(c.idx);
    if (c.kind > REQ_DELETE) begin
      r.status = STAT_ARG;
    end else if (!(i < TABLE_DEPTH && cap_owner[i] == c.who)) begin
      r.status = STAT_ACCESS;
    end else begin
      r.status = STAT_OK;
      case (c.kind)
        REQ_GET: begin
          r.owner = cap_owner[i];
          r.pid   = cap_pid[i];
          r.free  = cap_free[i];
          r.size  = cap_size[i];
        end
        REQ_TRANSFER: begin
          cap_owner[i] = c.owner_to;
        end
        REQ_DERIVE: begin
          if (c.fuel == 0 || cap_free[i] < c.fuel) begin
            r.status = STAT_ARG;
          end else begin
            rest  = int'(cap_free[i]) - int'(c.fuel);
            child = i + rest;
            if (child >= TABLE_DEPTH) begin
              r.status = STAT_ARG;
            end else begin
              cap_free[i]      = FUEL_W'(rest);
              cap_owner[child] = c.owner_to;
              cap_pid[child]   = cap_pid[i];
              cap_free[child]  = c.fuel;
              cap_size[child]  = c.fuel;
              r.child          = IDX_W'(child);
            end
          end
        end
        REQ_REVOKE: begin
          steps = (c.limit != 0) ? int'(c.limit) : FUEL;
          for (int n = 0; n < steps && cap_free[i] < cap_size[i]; n++) begin
            child = i + int'(cap_free[i]);
            if (child >= TABLE_DEPTH || cap_free[child] == 0) break;
            cap_owner[child] = '0;
            sum = int'(cap_free[i]) + int'(cap_free[child]);
            cap_free[i] = (sum > int'(FUEL_MAX)) ? FUEL_MAX : FUEL_W'(sum);
          end
          if (cap_size[i] > cap_free[i]) r.unrevoked = cap_size[i] - cap_free[i];
        end
        default: begin
          cap_owner[i] = '0;
        end
      endcase
    end
    return r;
  endfunction

  task automatic offer(input cap_cmd_t c);
    cft_res_t r;
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, c.limit, c.fuel, c.owner_to, c.idx, c.who};
    s_axis_tuser_i  <= c.kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = cap_table_step(c);
    pending_results.push_back(c.typed ? c.want : r);
    kind_count[c.kind]++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string why, input cft_res_t want, input cft_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected st=%0d child=%0d owner=%0d pid=%0d free=%0d size=%0d unrev=%0d",
               why, want.status, want.child, want.owner, want.pid, want.free, want.size,
               want.unrevoked);
      $display("    actual   st=%0d child=%0d owner=%0d pid=%0d free=%0d size=%0d unrev=%0d",
               got.status, got.child, got.owner, got.pid, got.free, got.size, got.unrevoked);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    cft_res_t got;
    cft_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got           = '0;
      got.status    = m_axis_tuser_o;
      got.child     = m_axis_tdata_o[5:0];
      got.owner     = m_axis_tdata_o[13:6];
      got.pid       = m_axis_tdata_o[21:14];
      got.free      = m_axis_tdata_o[25:22];
      got.size      = m_axis_tdata_o[29:26];
      got.unrevoked = m_axis_tdata_o[33:30];
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("Result with no request outstanding", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.child != want.child ||
            got.owner != want.owner || got.pid != want.pid || got.free != want.free ||
            got.size != want.size || got.unrevoked != want.unrevoked) begin
          flag_mismatch($sformatf("Result %0d differs", results_seen), want, got);
        end
      end
    end
  end

  // The receiver normally stalls at random; on demand it holds off for a long stretch.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles     <= hold_cycles - 1;
    end else if (hold_asked != hold_done) begin
      m_axis_tready_i <= 1'b0;
      hold_done       <= hold_asked;
      hold_cycles     <= HOLD_OFF_CYCLES;
    end else begin
      m_axis_tready_i <= calm || ($urandom_range(99) >= 11);
    end
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    cap_cmd_t c;
    int       tries;
    int       pick;

    for (int k = 0; k < TABLE_DEPTH; k++) begin
      cap_owner[k] = '0;
      cap_pid[k]   = '0;
      cap_free[k]  = '0;
      cap_size[k]  = '0;
    end
    for (int k = 0; k < NUM_PROCS; k++) begin
      if (k * FUEL < TABLE_DEPTH) begin
        cap_owner[k * FUEL] = OWNER_W'(1);
        cap_pid[k * FUEL]   = OWNER_W'(k + 1);
        cap_free[k * FUEL]  = FUEL_W'(FUEL);
        cap_size[k * FUEL]  = FUEL_W'(FUEL);
      end
    end
    foreach (kind_count[k]) kind_count[k] = 0;

    directed_cmds.push_back('{REQ_GET, 8'd1, 6'd0, 8'd0, 4'd0, 4'd0, 1'b1,
                              fixed(STAT_OK, 8'd1, 8'd1, 4'd8, 4'd8)});
    directed_cmds.push_back('{REQ_GET, 8'd1, 6'd56, 8'd0, 4'd0, 4'd0, 1'b1,
                              fixed(STAT_OK, 8'd1, 8'd8, 4'd8, 4'd8)});
    directed_cmds.push_back('{REQ_GET, 8'd0, 6'd63, 8'd0, 4'd0, 4'd0, 1'b1,
                              fixed(STAT_OK, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_GET, 8'd255, 6'd0, 8'd0, 4'd0, 4'd0, 1'b1,
                              fixed(STAT_ACCESS, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_RSVD_5, 8'd1, 6'd0, 8'd0, 4'd0, 4'd0, 1'b1,
                              fixed(STAT_ARG, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_RSVD_6, 8'd1, 6'd8, 8'd1, 4'd1, 4'd1, 1'b1,
                              fixed(STAT_ARG, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_RSVD_7, 8'd255, 6'd63, 8'd255, 4'd15, 4'd15, 1'b1,
                              fixed(STAT_ARG, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_TRANSFER, 8'd2, 6'd8, 8'd3, 4'd0, 4'd0, 1'b1,
                              fixed(STAT_ACCESS, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_DERIVE, 8'd1, 6'd8, 8'd2, 4'd0, 4'd0, 1'b1,
                              fixed(STAT_ARG, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_DERIVE, 8'd1, 6'd8, 8'd2, 4'd9, 4'd0, 1'b1,
                              fixed(STAT_ARG, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_DERIVE, 8'd1, 6'd8, 8'd2, 4'd15, 4'd0, 1'b1,
                              fixed(STAT_ARG, 8'd0, 8'd0, 4'd0, 4'd0)});
    directed_cmds.push_back('{REQ_DERIVE, 8'd1, 6'd56, 8'd2, 4'd4, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_DERIVE, 8'd2, 6'd60, 8'd255, 4'd1, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_DERIVE, 8'd1, 6'd56, 8'd1, 4'd1, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_REVOKE, 8'd1, 6'd56, 8'd0, 4'd0, 4'd1, 1'b0, '0});
    directed_cmds.push_back('{REQ_REVOKE, 8'd1, 6'd56, 8'd0, 4'd0, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_GET, 8'd1, 6'd56, 8'd0, 4'd0, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_TRANSFER, 8'd1, 6'd0, 8'd255, 4'd0, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_GET, 8'd255, 6'd0, 8'd0, 4'd0, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_DELETE, 8'd255, 6'd0, 8'd0, 4'd0, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_GET, 8'd0, 6'd0, 8'd0, 4'd0, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_DERIVE, 8'd0, 6'd0, 8'd0, 4'd8, 4'd0, 1'b0, '0});
    directed_cmds.push_back('{REQ_REVOKE, 8'd0, 6'd1, 8'd0, 4'd0, 4'd15, 1'b0, '0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cmds[n]) offer(directed_cmds[n]);
    wait_for_results();

    for (int r = 0; r < RANDOM_REQUESTS; r++) begin
      calm = (r >= 700 && r < 950);
      if (r == 400) hold_asked++;
      if (r == 1100) wait_for_results();

      // Most requests aim at a live entry with its current owner, so that they get past
      // the access check and build up chains of derived children.
      c.idx = IDX_W'($urandom_range(TABLE_DEPTH - 1));
      if ($urandom_range(99) < 75) begin
        tries = 0;
        while (cap_size[c.idx] == 0 && tries < 8) begin
          c.idx = IDX_W'($urandom_range(TABLE_DEPTH - 1));
          tries++;
        end
      end
      c.who = ($urandom_range(99) < 85) ? cap_owner[c.idx] : OWNER_W'($urandom);
      pick  = $urandom_range(99);
      if (pick < 20) c.kind = REQ_GET;
      else if (pick < 32) c.kind = REQ_TRANSFER;
      else if (pick < 62) c.kind = REQ_DERIVE;
      else if (pick < 82) c.kind = REQ_REVOKE;
      else if (pick < 90) c.kind = REQ_DELETE;
      else c.kind = 3'($urandom_range(7, 5));
      c.owner_to = ($urandom_range(3) == 0) ? OWNER_W'($urandom) : OWNER_W'($urandom_range(3, 1));
      if ($urandom_range(99) < 80 && cap_free[c.idx] != 0)
        c.fuel = FUEL_W'($urandom_range(cap_free[c.idx], 1));
      else
        c.fuel = FUEL_W'($urandom);
      c.limit = ($urandom_range(1) == 0) ? '0 : FUEL_W'($urandom);
      c.typed = 1'b0;
      c.want  = '0;
      offer(c);
    end
    calm = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d get, %0d transfer, %0d derive, %0d revoke, %0d delete,",
             directed_cmds.size() + RANDOM_REQUESTS, kind_count[REQ_GET],
             kind_count[REQ_TRANSFER], kind_count[REQ_DERIVE], kind_count[REQ_REVOKE],
             kind_count[REQ_DELETE]);
    $display("%0d of reserved type; %0d results compared, %0d mismatches.",
             kind_count[REQ_RSVD_5] + kind_count[REQ_RSVD_6] + kind_count[REQ_RSVD_7],
             results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cft_pkg.sv
hdl/cft_store.sv
hdl/capability_fuel_table_top.sv
dv/tb_capability_fuel_table_top.sv
